// ----- rtl/sia_pkg.sv -----
// ============================================================================
// sia_pkg - shared constants and types for the segment intersection block
// Widths, field packing and the per-stage payload records.
// ============================================================================
package sia_pkg;

  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned CW = 32;           // coordinate width
  localparam int unsigned DW = CW + 1;       // difference width
  localparam int unsigned PW = 2 * DW;       // product width
  localparam int unsigned SW = PW + 1;       // side value width
  localparam int unsigned NW = SW + 1;       // divider remainder width
  localparam int unsigned IN_W  = 10 * CW;
  localparam int unsigned OUT_W = 3 * CW + 8;
  localparam int unsigned PIPE_STAGES = FRAC_BITS + 5;  // register stages

endpackage

// ----- rtl/segment_intersection_2d_top.sv -----
// ============================================================================
// segment_intersection_2d_top - strict 2-D segment crossing test
// Side tests by exact cross products, u = S/(S-E) by a pipelined restoring
// divider, and the crossing point interpolated along segment one.
// ============================================================================
// Usage:
//   Input channel in_*: one transaction carries both segments. in_tdata holds,
//   from bit 0 up, seg1 start x/y/z, seg1 end x/y/z, seg2 start x/y and
//   seg2 end x/y, each 32-bit signed Q16.16.
//   Output channel out_*: one transaction per input. out_tdata holds, from
//   bit 0 up, hit in bit 0, then cross_x, cross_y, cross_z (Q16.16, zero on
//   a miss), padded with zeros to 104 bits.
//   Pipeline: stage 1 differences, stage 2 products, stage 3 side values and
//   hit, then FRAC_BITS divider stages (one quotient bit each), then one
//   product stage and one add stage. Throughput is one transaction per
//   cycle while the output is not stalled.
//   The whole pipe advances together: when out_tready is low and the output
//   register holds data, every stage freezes and in_tready falls, so nothing
//   is lost or repeated. Empty stages ahead of a stalled output are not
//   compacted.
//   Reset clears all valid bits; payload registers are not reset.
// ============================================================================
module segment_intersection_2d_top (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  // seg1_start_x, seg1_start_y, seg1_start_z, seg1_end_x, seg1_end_y,
  // seg1_end_z, seg2_start_x, seg2_start_y, seg2_end_x, seg2_end_y
  input  logic [sia_pkg::IN_W-1:0]    in_tdata,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  // hit, cross_x, cross_y, cross_z
  output logic [sia_pkg::OUT_W-1:0]   out_tdata
);
  import sia_pkg::*;

  logic adv;
  logic [PIPE_STAGES-1:0] v_r;

  assign adv       = !v_r[PIPE_STAGES-1] || out_tready;
  assign in_tready = adv;
  assign out_tvalid = v_r[PIPE_STAGES-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[PIPE_STAGES-2:0], in_tvalid};
    end
  end

  function automatic logic signed [CW-1:0] fld(input logic [IN_W-1:0] d, input int i);
    fld = d[i*CW +: CW];
  endfunction

  // stage 1: differences
  logic signed [DW-1:0] d1x_r, d1y_r, d2x_r, d2y_r, d1z_r;
  logic signed [DW-1:0] psx_r, psy_r, pex_r, pey_r, qsx_r, qsy_r, qex_r, qey_r;
  logic signed [CW-1:0] s1x_r, s1y_r, s1z_r;
  // stage 2: products
  logic signed [PW-1:0] m_r [8];
  logic signed [DW-1:0] a1x_r, a1y_r, a1z_r;
  logic signed [CW-1:0] b1x_r, b1y_r, b1z_r;
  // stage 3 (entry 0) and divider stages
  logic [NW-1:0] rem_r [FRAC_BITS+1];
  logic [NW-1:0] dv_r  [FRAC_BITS+1];
  logic [FRAC_BITS-1:0] q_r [FRAC_BITS+1];
  logic          h_r   [FRAC_BITS+1];
  logic signed [DW-1:0] dx_r [FRAC_BITS+1], dy_r [FRAC_BITS+1], dz_r [FRAC_BITS+1];
  logic signed [CW-1:0] sx_r [FRAC_BITS+1], sy_r [FRAC_BITS+1], sz_r [FRAC_BITS+1];
  // product stage
  logic signed [DW+FRAC_BITS:0] px_r, py_r, pz_r;
  logic signed [CW-1:0] tx_r, ty_r, tz_r;
  logic hp_r;
  logic [OUT_W-1:0] out_r;

  logic signed [SW-1:0] sv, ev, tv, fv, sme;
  logic opp1, opp2;

  always_comb begin
    sv = SW'(m_r[0]) - SW'(m_r[1]);
    ev = SW'(m_r[2]) - SW'(m_r[3]);
    tv = SW'(m_r[4]) - SW'(m_r[5]);
    fv = SW'(m_r[6]) - SW'(m_r[7]);
    sme = sv - ev;
    opp1 = (sv != 0) && (ev != 0) && (sv[SW-1] != ev[SW-1]);
    opp2 = (tv != 0) && (fv != 0) && (tv[SW-1] != fv[SW-1]);
  end

  function automatic logic signed [DW-1:0] df(input logic signed [CW-1:0] a,
                                              input logic signed [CW-1:0] b);
    df = DW'(a) - DW'(b);
  endfunction

  function automatic logic signed [CW-1:0] lerp(input logic signed [CW-1:0] s,
                                                input logic signed [DW+FRAC_BITS:0] p);
    logic signed [DW+FRAC_BITS:0] sh;
    sh = p >>> FRAC_BITS;
    lerp = s + CW'(sh);
  endfunction

  logic [NW-1:0] sh_rem [FRAC_BITS];
  always_comb begin
    for (int k = 0; k < FRAC_BITS; k++) sh_rem[k] = rem_r[k] << 1;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1x_r <= fld(in_tdata, 0); s1y_r <= fld(in_tdata, 1); s1z_r <= fld(in_tdata, 2);
      d1x_r <= df(fld(in_tdata, 3), fld(in_tdata, 0));
      d1y_r <= df(fld(in_tdata, 4), fld(in_tdata, 1));
      d1z_r <= df(fld(in_tdata, 5), fld(in_tdata, 2));
      d2x_r <= df(fld(in_tdata, 8), fld(in_tdata, 6));
      d2y_r <= df(fld(in_tdata, 9), fld(in_tdata, 7));
      psx_r <= df(fld(in_tdata, 0), fld(in_tdata, 6));
      psy_r <= df(fld(in_tdata, 1), fld(in_tdata, 7));
      pex_r <= df(fld(in_tdata, 3), fld(in_tdata, 6));
      pey_r <= df(fld(in_tdata, 4), fld(in_tdata, 7));
      qsx_r <= df(fld(in_tdata, 6), fld(in_tdata, 0));
      qsy_r <= df(fld(in_tdata, 7), fld(in_tdata, 1));
      qex_r <= df(fld(in_tdata, 8), fld(in_tdata, 0));
      qey_r <= df(fld(in_tdata, 9), fld(in_tdata, 1));

      m_r[0] <= PW'(d2x_r) * PW'(psy_r);
      m_r[1] <= PW'(d2y_r) * PW'(psx_r);
      m_r[2] <= PW'(d2x_r) * PW'(pey_r);
      m_r[3] <= PW'(d2y_r) * PW'(pex_r);
      m_r[4] <= PW'(d1x_r) * PW'(qsy_r);
      m_r[5] <= PW'(d1y_r) * PW'(qsx_r);
      m_r[6] <= PW'(d1x_r) * PW'(qey_r);
      m_r[7] <= PW'(d1y_r) * PW'(qex_r);
      a1x_r <= d1x_r; a1y_r <= d1y_r; a1z_r <= d1z_r;
      b1x_r <= s1x_r; b1y_r <= s1y_r; b1z_r <= s1z_r;

      // stage 3 loads the divider entry
      rem_r[0] <= sv[SW-1] ? NW'(-sv) : NW'(sv);
      dv_r[0]  <= sme[SW-1] ? NW'(-sme) : NW'(sme);
      q_r[0]   <= '0;
      h_r[0]   <= opp1 && opp2;
      dx_r[0] <= a1x_r; dy_r[0] <= a1y_r; dz_r[0] <= a1z_r;
      sx_r[0] <= b1x_r; sy_r[0] <= b1y_r; sz_r[0] <= b1z_r;

      for (int k = 0; k < FRAC_BITS; k++) begin
        if (sh_rem[k] >= dv_r[k]) begin
          rem_r[k+1] <= sh_rem[k] - dv_r[k];
          q_r[k+1]   <= {q_r[k][FRAC_BITS-2:0], 1'b1};
        end else begin
          rem_r[k+1] <= sh_rem[k];
          q_r[k+1]   <= {q_r[k][FRAC_BITS-2:0], 1'b0};
        end
        dv_r[k+1] <= dv_r[k]; h_r[k+1] <= h_r[k];
        dx_r[k+1] <= dx_r[k]; dy_r[k+1] <= dy_r[k]; dz_r[k+1] <= dz_r[k];
        sx_r[k+1] <= sx_r[k]; sy_r[k+1] <= sy_r[k]; sz_r[k+1] <= sz_r[k];
      end

      px_r <= $signed({1'b0, q_r[FRAC_BITS]}) * dx_r[FRAC_BITS];
      py_r <= $signed({1'b0, q_r[FRAC_BITS]}) * dy_r[FRAC_BITS];
      pz_r <= $signed({1'b0, q_r[FRAC_BITS]}) * dz_r[FRAC_BITS];
      tx_r <= sx_r[FRAC_BITS]; ty_r <= sy_r[FRAC_BITS]; tz_r <= sz_r[FRAC_BITS];
      hp_r <= h_r[FRAC_BITS];

      out_r <= hp_r ? {7'd0, lerp(tz_r, pz_r), lerp(ty_r, py_r), lerp(tx_r, px_r), 1'b1}
                    : '0;
    end
  end

  assign out_tdata = out_r;

endmodule

// ----- rtl/sia_checker.sv -----
// ============================================================================
// sia_checker - port-level checks for segment_intersection_2d_top
// Handshake and result-format properties seen at the ports.
// ============================================================================
module sia_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_tvalid,
  input logic                      in_tready,
  input logic                      out_tvalid,
  input logic                      out_tready,
  input logic [sia_pkg::OUT_W-1:0] out_tdata
);
  import sia_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output dropped under stall");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[0] |-> out_tdata[3*CW:1] == '0)
    else $error("miss with nonzero coordinates");

  a_pad: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[OUT_W-1:3*CW+1] == '0)
    else $error("padding bits set");

  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty output");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

endmodule

bind segment_intersection_2d_top sia_checker u_sia_checker (.*);
